// File: design/ghash_pkg.sv
package ghash_pkg;

  // Field widths of the item and result beats.
  localparam int unsigned OP_W        = 2;
  localparam int unsigned HALF_W      = 64;
  localparam int unsigned BLOCK_W     = 128;
  localparam int unsigned BLOCK_BYTES = 16;
  localparam int unsigned NBYTES_W    = 5;
  localparam int unsigned LEN_W       = 32;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  // Default depth of the queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Operation codes on the input channel.
  localparam logic [OP_W-1:0] OP_START  = 2'd0;
  localparam logic [OP_W-1:0] OP_ABSORB = 2'd1;
  localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_HASH_KEY_HIGH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HASH_KEY_LOW     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_VALUE_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_VALUE_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AAD_LENGTH_BYTES = 3'd4;

  // Command that the front hands to the back.
  typedef enum logic [1:0] {
    CMD_START,
    CMD_ABSORB,
    CMD_FINISH
  } cmd_e;

  // One queued command with its masked block and clamped byte count.
  typedef struct packed {
    cmd_e                cmd;
    logic [BLOCK_W-1:0]  block;
    logic [NBYTES_W-1:0] nbytes;
  } entry_t;

  // Configuration seen by the back.
  typedef struct packed {
    logic [BLOCK_W-1:0] hash_key;
    logic [BLOCK_W-1:0] start_value;
    logic [LEN_W-1:0]   aad_len;
  } cfg_t;

  // Queue status toward front and back.
  typedef struct packed {
    logic full;
    logic nonempty;
  } q_stat_t;

endpackage

// File: design/ghash_if.sv
// Input channel: one command beat.
interface ghash_in_if;
  import ghash_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [HALF_W-1:0]   block_high;
  logic [HALF_W-1:0]   block_low;
  logic [NBYTES_W-1:0] valid_bytes;

  modport source (
    output valid, operation, block_high, block_low, valid_bytes,
    input  ready
  );

  modport sink (
    input  valid, operation, block_high, block_low, valid_bytes,
    output ready
  );
endinterface

// Output channel: one tag beat.
interface ghash_out_if;
  import ghash_pkg::*;

  logic              valid;
  logic              ready;
  logic [HALF_W-1:0] tag_high;
  logic [HALF_W-1:0] tag_low;

  modport source (
    output valid, tag_high, tag_low,
    input  ready
  );

  modport sink (
    input  valid, tag_high, tag_low,
    output ready
  );
endinterface

// File: design/ghash_front.sv
module ghash_front (
  ghash_in_if.sink            in_i,
  input  ghash_pkg::q_stat_t  stat_i,
  output logic                push_o,
  output ghash_pkg::entry_t   entry_o
);
  import ghash_pkg::*;

  logic [NBYTES_W-1:0] nbytes;
  logic [BLOCK_W-1:0]  mask;
  logic                keep;

  // Take a beat whenever the queue has room.
  assign in_i.ready = !stat_i.full;

  // Clamp the byte count to one block.
  assign nbytes = (in_i.valid_bytes > NBYTES_W'(BLOCK_BYTES)) ?
                  NBYTES_W'(BLOCK_BYTES) : in_i.valid_bytes;

  // Keep the leading bytes only; byte 0 sits in the top bits.
  always_comb begin
    mask = '0;
    for (int b = 0; b < BLOCK_BYTES; b++) begin
      mask[BLOCK_W-1-8*b -: 8] = {8{NBYTES_W'(b) < nbytes}};
    end
  end

  // Classify the beat; unknown operations and empty absorbs are dropped.
  always_comb begin
    entry_o.block  = {in_i.block_high, in_i.block_low} & mask;
    entry_o.nbytes = nbytes;
    entry_o.cmd    = CMD_START;
    keep           = 1'b0;
    unique case (in_i.operation)
      OP_START: begin
        entry_o.cmd = CMD_START;
        keep        = 1'b1;
      end
      OP_ABSORB: begin
        entry_o.cmd = CMD_ABSORB;
        keep        = (in_i.valid_bytes != '0);
      end
      OP_FINISH: begin
        entry_o.cmd = CMD_FINISH;
        keep        = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push_o = in_i.valid && in_i.ready && keep;

endmodule

// File: design/ghash_queue.sv
module ghash_queue #(
  parameter int unsigned Depth = ghash_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ghash_pkg::entry_t  entry_i,
  input  logic               pop_i,
  output ghash_pkg::entry_t  head_o,
  output ghash_pkg::q_stat_t stat_o
);
  import ghash_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  // Pointer and fill count updates, with wrap at the last slot.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage; payload only, no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  assign head_o          = mem_q[rd_ptr_q];
  assign stat_o.full     = (cnt_q == CntW'(Depth));
  assign stat_o.nonempty = (cnt_q != '0);

endmodule

// File: design/ghash_back.sv
module ghash_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ghash_pkg::cfg_t    cfg_i,
  input  ghash_pkg::entry_t  head_i,
  input  ghash_pkg::q_stat_t stat_i,
  output logic               pop_o,
  ghash_out_if.source        out_o
);
  import ghash_pkg::*;

  // Multiply in GF(2^128) with the GCM bit order: bit 127 of the word is x^0.
  function automatic logic [BLOCK_W-1:0] gf_mul(logic [BLOCK_W-1:0] a,
                                                logic [BLOCK_W-1:0] h);
    logic [BLOCK_W-1:0]   ar;
    logic [BLOCK_W-1:0]   hr;
    logic [2*BLOCK_W-2:0] p;
    logic [BLOCK_W-2:0]   hi;
    logic [BLOCK_W+5:0]   t;
    logic [12:0]          g;
    logic [BLOCK_W-1:0]   r;
    logic [BLOCK_W-1:0]   res;
    for (int i = 0; i < BLOCK_W; i++) begin
      ar[i] = a[BLOCK_W-1-i];
      hr[i] = h[BLOCK_W-1-i];
    end
    // Carry-less product from independent partial products.
    p = '0;
    for (int i = 0; i < BLOCK_W; i++) begin
      p = p ^ (({{(BLOCK_W-1){1'b0}}, ar} & {(2*BLOCK_W-1){hr[i]}}) << i);
    end
    // Fold the upper half twice with x^128 = x^7 + x^2 + x + 1.
    hi = p[2*BLOCK_W-2:BLOCK_W];
    t  = {7'b0, hi} ^ ({7'b0, hi} << 1) ^ ({7'b0, hi} << 2) ^ ({7'b0, hi} << 7);
    g  = {7'b0, t[BLOCK_W+5:BLOCK_W]};
    g  = g ^ (g << 1) ^ (g << 2) ^ (g << 7);
    r  = p[BLOCK_W-1:0] ^ t[BLOCK_W-1:0] ^ {{(BLOCK_W-13){1'b0}}, g};
    for (int i = 0; i < BLOCK_W; i++) begin
      res[i] = r[BLOCK_W-1-i];
    end
    return res;
  endfunction

  logic [BLOCK_W-1:0] acc_q;
  logic [LEN_W-1:0]   cnt_q;
  logic               out_valid_q;
  logic [BLOCK_W-1:0] tag_q;
  logic [BLOCK_W-1:0] len_blk;
  logic [BLOCK_W-1:0] mul_in;
  logic [BLOCK_W-1:0] product;
  logic               out_free;

  // A finish waits only while an untaken tag still sits in the output register.
  assign out_free = !out_valid_q || out_o.ready;
  assign pop_o    = stat_i.nonempty && ((head_i.cmd != CMD_FINISH) || out_free);

  // Lengths block: AAD bits above, data bits below, each modulo 2^32.
  assign len_blk = {{(HALF_W-LEN_W){1'b0}}, cfg_i.aad_len[LEN_W-4:0], 3'b000,
                    {(HALF_W-LEN_W){1'b0}}, cnt_q[LEN_W-4:0], 3'b000};

  // One shared multiplier for absorb and finish.
  assign mul_in  = acc_q ^ ((head_i.cmd == CMD_FINISH) ? len_blk : head_i.block);
  assign product = gf_mul(mul_in, cfg_i.hash_key);

  // Accumulator, byte count and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (pop_o) begin
        unique case (head_i.cmd)
          CMD_START: begin
            acc_q <= cfg_i.start_value;
            cnt_q <= '0;
          end
          CMD_ABSORB: begin
            acc_q <= product;
            cnt_q <= cnt_q + LEN_W'(head_i.nbytes);
          end
          CMD_FINISH: begin
            acc_q       <= product;
            out_valid_q <= 1'b1;
          end
          default: begin
            acc_q <= acc_q;
          end
        endcase
      end
    end
  end

  // Tag payload register.
  always_ff @(posedge clk_i) begin
    if (pop_o && (head_i.cmd == CMD_FINISH)) begin
      tag_q <= product;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.tag_high = tag_q[BLOCK_W-1:HALF_W];
  assign out_o.tag_low  = tag_q[HALF_W-1:0];

endmodule

// File: design/ghash_gf128_accumulator_top.sv
// GHASH accumulator. Throughput: one beat per cycle while the queue has room and
// no finish waits on an untaken tag, set by the combinational GF(2^128) multiply
// in the accumulator feedback loop of the back end. A command is queued when its
// beat is accepted and runs when popped from the queue head; a finish shows its
// tag on the output channel in the next cycle. Reset clears the configuration
// registers, accumulator, byte count, queue and output valid; input is ready out of reset.
module ghash_gf128_accumulator_top #(
  parameter int unsigned QueueDepth = ghash_pkg::QUEUE_DEPTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ghash_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ghash_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  ghash_in_if.sink                           in_i,
  ghash_out_if.source                        out_o
);
  import ghash_pkg::*;

  cfg_t    cfg_q;
  entry_t  push_entry;
  entry_t  head;
  q_stat_t stat;
  logic    push;
  logic    pop;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HASH_KEY_HIGH:    cfg_q.hash_key[BLOCK_W-1:HALF_W]    <= cfg_data_i;
        CFG_HASH_KEY_LOW:     cfg_q.hash_key[HALF_W-1:0]          <= cfg_data_i;
        CFG_START_VALUE_HIGH: cfg_q.start_value[BLOCK_W-1:HALF_W] <= cfg_data_i;
        CFG_START_VALUE_LOW:  cfg_q.start_value[HALF_W-1:0]       <= cfg_data_i;
        CFG_AAD_LENGTH_BYTES: cfg_q.aad_len <= cfg_data_i[LEN_W-1:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  ghash_front u_front (
    .in_i    (in_i),
    .stat_i  (stat),
    .push_o  (push),
    .entry_o (push_entry)
  );

  ghash_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .head_o  (head),
    .stat_o  (stat)
  );

  ghash_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .head_i (head),
    .stat_i (stat),
    .pop_o  (pop),
    .out_o  (out_o)
  );

  // The back never pops an empty queue.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> stat.nonempty)
    else $error("queue popped while empty");

  // A full queue is never empty.
  a_full_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.full |-> stat.nonempty)
    else $error("queue full and empty at once");

  // An executed finish puts a tag on the output in the next cycle.
  a_finish_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && (head.cmd == CMD_FINISH)) |=> out_o.valid)
    else $error("finish executed without a tag");

  // An undefined operation never reaches the queue.
  a_drop_unknown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && (in_i.operation != OP_START) &&
     (in_i.operation != OP_ABSORB) && (in_i.operation != OP_FINISH)) |-> !push)
    else $error("undefined operation queued");

endmodule

// File: tb/sv/ghash_tag_checker.sv
`timescale 1ns / 100ps

// Watches the configuration port and both channels of the GHASH block, keeps
// its own copy of the accumulator, and compares every tag beat with the
// oldest predicted tag.
module ghash_tag_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ghash_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ghash_pkg::CFG_DATA_W-1:0] cfg_data_i,
  ghash_in_if                              in_i,
  ghash_out_if                             out_i,
  output int unsigned                      open_tags_o,
  output int unsigned                      error_count_o
);
  import ghash_pkg::*;

  // Reduction polynomial in the reflected GCM bit order.
  localparam logic [BLOCK_W-1:0] GF_REDUCE = {8'he1, {(BLOCK_W-8){1'b0}}};

  logic [BLOCK_W-1:0] hash_key;
  logic [BLOCK_W-1:0] start_value;
  logic [LEN_W-1:0]   aad_len;
  logic [BLOCK_W-1:0] ghash_acc;
  logic [LEN_W-1:0]   data_len;
  logic [BLOCK_W-1:0] expected_tags[$];
  int unsigned        mismatches;

  // Bit-serial GF(2^128) multiply; bit 0 of the field element is the MSB.
  function automatic logic [BLOCK_W-1:0] gf128_mul(input logic [BLOCK_W-1:0] x,
                                                   input logic [BLOCK_W-1:0] h);
    logic [BLOCK_W-1:0] v;
    logic [BLOCK_W-1:0] z;
    int                 i;
    v = x;
    z = '0;
    for (i = 0; i < BLOCK_W; i++) begin
      if (h[BLOCK_W-1-i]) begin
        z = z ^ v;
      end
      v = v[0] ? ((v >> 1) ^ GF_REDUCE) : (v >> 1);
    end
    return z;
  endfunction

  // Compare outgoing tags first, then advance the prediction with the input beat.
  always @(posedge clk_i or negedge rst_ni) begin : predict_and_compare
    int unsigned        nbytes;
    logic [BLOCK_W-1:0] blk;
    logic [BLOCK_W-1:0] lens;
    logic [BLOCK_W-1:0] tag_exp;
    if (!rst_ni) begin
      hash_key      = '0;
      start_value   = '0;
      aad_len       = '0;
      ghash_acc     = '0;
      data_len      = '0;
      mismatches    = 0;
      expected_tags.delete();
      open_tags_o   <= 0;
      error_count_o <= 0;
    end else begin
      // A tag beat retires the oldest prediction.
      if (out_i.valid && out_i.ready) begin
        if (expected_tags.size() == 0) begin
          $error("tag beat %h_%h with no finish outstanding", out_i.tag_high, out_i.tag_low);
          mismatches++;
        end else begin
          tag_exp = expected_tags.pop_front();
          if (out_i.tag_high !== tag_exp[BLOCK_W-1:HALF_W]) begin
            $error("tag_high: expected %h, actual %h", tag_exp[BLOCK_W-1:HALF_W],
                   out_i.tag_high);
            mismatches++;
          end
          if (out_i.tag_low !== tag_exp[HALF_W-1:0]) begin
            $error("tag_low: expected %h, actual %h", tag_exp[HALF_W-1:0], out_i.tag_low);
            mismatches++;
          end
        end
      end

      // Command beat.
      if (in_i.valid && in_i.ready) begin
        case (in_i.operation)
          OP_START: begin
            ghash_acc = start_value;
            data_len  = '0;
          end
          OP_ABSORB: begin
            nbytes = 32'(in_i.valid_bytes);
            if (nbytes != 0) begin
              if (nbytes > BLOCK_BYTES) begin
                nbytes = BLOCK_BYTES;
              end
              // Bytes past the valid count are dropped before the XOR.
              blk = {in_i.block_high, in_i.block_low} &
                    ({BLOCK_W{1'b1}} << (8 * (BLOCK_BYTES - nbytes)));
              ghash_acc = gf128_mul(ghash_acc ^ blk, hash_key);
              data_len  = data_len + LEN_W'(nbytes);
            end
          end
          OP_FINISH: begin
            // Bit lengths are taken modulo 2^32.
            lens = {{(HALF_W-LEN_W){1'b0}}, aad_len << 3,
                    {(HALF_W-LEN_W){1'b0}}, data_len << 3};
            ghash_acc = gf128_mul(ghash_acc ^ lens, hash_key);
            expected_tags.push_back(ghash_acc);
          end
          default: begin
          end
        endcase
      end

      // Register write.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_HASH_KEY_HIGH:    hash_key[BLOCK_W-1:HALF_W]    = cfg_data_i;
          CFG_HASH_KEY_LOW:     hash_key[HALF_W-1:0]          = cfg_data_i;
          CFG_START_VALUE_HIGH: start_value[BLOCK_W-1:HALF_W] = cfg_data_i;
          CFG_START_VALUE_LOW:  start_value[HALF_W-1:0]       = cfg_data_i;
          CFG_AAD_LENGTH_BYTES: aad_len                       = cfg_data_i[LEN_W-1:0];
          default: begin
          end
        endcase
      end

      open_tags_o   <= expected_tags.size();
      error_count_o <= mismatches;
    end
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import ghash_pkg::*;

  // The one operation code the block ignores.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_BEATS = 240;
  localparam int unsigned TAIL_CYCLES = 10;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int unsigned           send_idle_pct;
  int unsigned           recv_stall_pct;
  int unsigned           open_tags;
  int unsigned           error_count;

  ghash_in_if  in_if ();
  ghash_out_if out_if ();

  ghash_gf128_accumulator_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  ghash_tag_checker i_tag_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_i          (in_if),
    .out_i         (out_if),
    .open_tags_o   (open_tags),
    .error_count_o (error_count)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // The tag receiver stalls at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [BLOCK_W-1:0] random_block();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // Keeps the first nb bytes (1 to 16) of a block and zeroes the rest.
  function automatic logic [BLOCK_W-1:0] keep_bytes(input logic [BLOCK_W-1:0] blk,
                                                    input int unsigned nb);
    return blk & ({BLOCK_W{1'b1}} << (8 * (BLOCK_BYTES - nb)));
  endfunction

  // Full blocks half the time, otherwise a short tail block.
  function automatic logic [NBYTES_W-1:0] pick_count();
    if ($urandom_range(1) == 0) begin
      return NBYTES_W'(BLOCK_BYTES);
    end
    return NBYTES_W'($urandom_range(1, BLOCK_BYTES - 1));
  endfunction

  // Presents one command beat after a random gap and holds it until accepted.
  task automatic drive_beat(input logic [OP_W-1:0] op, input logic [BLOCK_W-1:0] blk,
                            input logic [NBYTES_W-1:0] nb);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.operation   <= op;
    in_if.block_high  <= blk[BLOCK_W-1:HALF_W];
    in_if.block_low   <= blk[HALF_W-1:0];
    in_if.valid_bytes <= nb;
    @(posedge clk_i);
    while (!in_if.ready) begin
      @(posedge clk_i);
    end
  endtask

  // Stops sending and waits until every tag is out and the queue has drained.
  task automatic settle();
    in_if.valid <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (open_tags != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
  endtask

  // Loads a full key, start value and AAD length while the block is idle.
  task automatic program_setting(input logic [BLOCK_W-1:0] key,
                                 input logic [BLOCK_W-1:0] start,
                                 input logic [LEN_W-1:0] aad);
    settle();
    write_reg(CFG_HASH_KEY_HIGH, key[BLOCK_W-1:HALF_W]);
    write_reg(CFG_HASH_KEY_LOW, key[HALF_W-1:0]);
    write_reg(CFG_START_VALUE_HIGH, start[BLOCK_W-1:HALF_W]);
    write_reg(CFG_START_VALUE_LOW, start[HALF_W-1:0]);
    write_reg(CFG_AAD_LENGTH_BYTES, CFG_DATA_W'(aad));
    cfg_we <= 1'b0;
  endtask

  task automatic set_idling(input int unsigned mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
      default: begin send_idle_pct = 10; recv_stall_pct = 10; end
    endcase
  endtask

  initial begin
    int unsigned          phase;
    int unsigned          sent;
    int unsigned          absorbs;
    int unsigned          k;
    bit                   paused;
    logic [NBYTES_W-1:0]  nb;
    logic [BLOCK_W-1:0]   blk;

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    paused         = 1'b0;
    rst_ni            <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_idx           <= '0;
    cfg_data          <= '0;
    in_if.valid       <= 1'b0;
    in_if.operation   <= OP_START;
    in_if.block_high  <= '0;
    in_if.block_low   <= '0;
    in_if.valid_bytes <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part; the AAD length overflows 32 bits once scaled to bits.
    program_setting(random_block(), random_block(), 32'h2000_0001);
    drive_beat(OP_FINISH, '0, '0);
    drive_beat(OP_START, random_block(), 5'd31);
    drive_beat(OP_ABSORB, {BLOCK_W{1'b1}}, 5'd16);
    drive_beat(OP_ABSORB, '0, 5'd16);
    drive_beat(OP_ABSORB, {BLOCK_W{1'b1}}, 5'd1);
    drive_beat(OP_ABSORB, random_block(), 5'd8);
    drive_beat(OP_ABSORB, random_block(), 5'd9);
    drive_beat(OP_ABSORB, random_block(), 5'd15);
    drive_beat(OP_ABSORB, random_block(), 5'd0);
    drive_beat(OP_ABSORB, random_block(), 5'd17);
    drive_beat(OP_ABSORB, {BLOCK_W{1'b1}}, 5'd31);
    drive_beat(OP_UNUSED, {BLOCK_W{1'b1}}, 5'd16);
    drive_beat(OP_FINISH, random_block(), 5'd16);
    drive_beat(OP_FINISH, '0, '0);
    drive_beat(OP_START, '0, '0);
    drive_beat(OP_FINISH, '0, '0);
    drive_beat(OP_START, random_block(), 5'd3);
    drive_beat(OP_ABSORB, keep_bytes(random_block(), 5), 5'd5);
    drive_beat(OP_FINISH, random_block(), 5'd31);

    // Random part: mostly complete messages, with some noise in between.
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: program_setting({BLOCK_W{1'b1}}, {BLOCK_W{1'b1}}, {LEN_W{1'b1}});
        1: program_setting('0, '0, '0);
        2: program_setting({1'b1, {(BLOCK_W-1){1'b0}}}, random_block(), $urandom);
        default: program_setting(random_block(), random_block(), $urandom);
      endcase
      set_idling(phase % 4);
      sent = 0;
      while (sent < PHASE_BEATS) begin
        if ($urandom_range(99) < 85) begin
          drive_beat(OP_START, random_block(), NBYTES_W'($urandom_range(31)));
          absorbs = $urandom_range(0, 6);
          for (k = 0; k < absorbs; k++) begin
            nb  = pick_count();
            blk = random_block();
            // Usually zero padding, sometimes junk past the valid bytes.
            if ($urandom_range(3) != 0) begin
              blk = keep_bytes(blk, nb);
            end
            drive_beat(OP_ABSORB, blk, nb);
          end
          drive_beat(OP_FINISH, random_block(), NBYTES_W'($urandom_range(31)));
          sent += absorbs + 2;
        end else begin
          case ($urandom_range(4))
            0: drive_beat(OP_UNUSED, random_block(), NBYTES_W'($urandom_range(31)));
            1: begin
              if ($urandom_range(1) == 0) begin
                drive_beat(OP_ABSORB, random_block(), '0);
              end else begin
                drive_beat(OP_ABSORB, random_block(), NBYTES_W'($urandom_range(17, 31)));
                sent++;
              end
            end
            2: begin
              drive_beat(OP_FINISH, random_block(), NBYTES_W'($urandom_range(31)));
              sent++;
            end
            3: begin
              drive_beat(OP_ABSORB, random_block(), pick_count());
              sent++;
            end
            default: begin
              drive_beat(OP_START, random_block(), NBYTES_W'($urandom_range(31)));
              sent++;
            end
          endcase
        end
        // Once in the run, let the block run completely dry mid-phase.
        if (phase == 5 && !paused && sent >= PHASE_BEATS / 2) begin
          settle();
          paused = 1'b1;
        end
      end
    end

    settle();
    if (error_count == 0 && open_tags == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
design/ghash_pkg.sv
design/ghash_if.sv
design/ghash_front.sv
design/ghash_queue.sv
design/ghash_back.sv
design/ghash_gf128_accumulator_top.sv
tb/sv/ghash_tag_checker.sv
tb/sv/testbench.sv
